@@ hdl/iee_pkg.sv @@
// ----------------------------------------------------------------------------
// iee_pkg: shared types and constants
// Operator and error codes, character classes, controller states and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package iee_pkg;

  localparam int unsigned DataW = 32;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_MUL    = 8'h2A;
  localparam logic [7:0] CH_ADD    = 8'h2B;
  localparam logic [7:0] CH_SUB    = 8'h2D;
  localparam logic [7:0] CH_DIV    = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;

  typedef enum logic [2:0] {
    OP_LPAREN = 3'd0,
    OP_ADD    = 3'd1,
    OP_SUB    = 3'd2,
    OP_MUL    = 3'd3,
    OP_DIV    = 3'd4,
    OP_OTHER  = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_DIV0  = 2'd1,
    ERR_STACK = 2'd2,
    ERR_PAREN = 2'd3
  } err_e;

  typedef enum logic [2:0] {
    CLS_SPACE,
    CLS_ALNUM,
    CLS_LPAREN,
    CLS_RPAREN,
    CLS_OPER
  } cls_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_UW_RD,
    S_UW_CHK,
    S_AP_START,
    S_AP_RB,
    S_AP_RA,
    S_AP_EXEC,
    S_AP_DIV,
    S_END_RD,
    S_END_CHK,
    S_END_FIN
  } state_e;

  typedef struct packed {
    logic in_ready;
    logic push_char;
    logic push_op;
    logic op_pop;
    logic latch_opr;
    logic push_zero;
    logic sel_second;
    logic cap_b;
    logic cap_a;
    logic div_start;
    logic write_result;
    logic load_out;
    logic err_set;
    err_e err_code;
  } cmd_t;

  typedef struct packed {
    cls_e cls;
    logic last;
    logic op_empty;
    logic top_lparen;
    logic top_prec_lt;
    logic val_lt2;
    logic div_needed;
    logic div_done;
    logic out_busy;
  } sts_t;

  function automatic cls_e char_class(logic [7:0] c);
    cls_e r;
    if (c == CH_SPACE) r = CLS_SPACE;
    else if ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h61 && c <= 8'h7A)) r = CLS_ALNUM;
    else if (c == CH_LPAREN) r = CLS_LPAREN;
    else if (c == CH_RPAREN) r = CLS_RPAREN;
    else r = CLS_OPER;
    return r;
  endfunction

  function automatic op_e op_of(logic [7:0] c);
    op_e r;
    case (c)
      CH_ADD:  r = OP_ADD;
      CH_SUB:  r = OP_SUB;
      CH_MUL:  r = OP_MUL;
      CH_DIV:  r = OP_DIV;
      default: r = OP_OTHER;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] prec_of(op_e op);
    logic [1:0] r;
    case (op)
      OP_ADD, OP_SUB: r = 2'd1;
      OP_MUL, OP_DIV: r = 2'd2;
      default:        r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/iee_in_if.sv @@
// ----------------------------------------------------------------------------
// iee_in_if: character channel
// Valid/ready channel carrying one expression character.
// ----------------------------------------------------------------------------
interface iee_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

@@ hdl/iee_out_if.sv @@
// ----------------------------------------------------------------------------
// iee_out_if: result channel
// Valid/ready channel carrying the evaluated value and error code.
// ----------------------------------------------------------------------------
interface iee_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic [1:0]         error_code;

  modport source (output valid, output value, output error_code, input ready);
  modport sink   (input valid, input value, input error_code, output ready);
endinterface

@@ hdl/iee_ram.sv @@
// ----------------------------------------------------------------------------
// iee_ram: generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module iee_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ hdl/iee_div.sv @@
// ----------------------------------------------------------------------------
// iee_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle, done pulse at the end.
// ----------------------------------------------------------------------------
module iee_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quotient_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;
  logic [31:0] dvs_q, dvs_d;
  logic [32:0] trial;
  logic [32:0] diff;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    trial  = {rem_q, quo_q[31]};
    diff   = trial - {1'b0, dvs_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 6'd32;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (!diff[32]) begin
        rem_d = diff[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = trial[31:0];
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

@@ hdl/iee_ctrl.sv @@
// ----------------------------------------------------------------------------
// iee_ctrl: evaluator controller
// Sequences character dispatch, operator unwinding, operator application and
// final result delivery.
// ----------------------------------------------------------------------------
module iee_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  iee_pkg::sts_t  sts_i,
  input  logic           in_valid_i,
  output iee_pkg::cmd_t  cmd_o
);

  iee_pkg::state_e state_q, state_d;
  logic            end_mode_q, end_mode_d;
  iee_pkg::state_e ret_state;
  iee_pkg::state_e done_state;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= iee_pkg::S_IDLE;
      end_mode_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      end_mode_q <= end_mode_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    end_mode_d = end_mode_q;
    cmd_o      = '0;
    cmd_o.err_code = iee_pkg::ERR_NONE;
    ret_state  = end_mode_q ? iee_pkg::S_END_RD : iee_pkg::S_UW_RD;
    done_state = sts_i.last ? iee_pkg::S_END_RD : iee_pkg::S_IDLE;
    unique case (state_q)
      iee_pkg::S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (in_valid_i) begin
          state_d = iee_pkg::S_DISPATCH;
        end
      end
      iee_pkg::S_DISPATCH: begin
        unique case (sts_i.cls)
          iee_pkg::CLS_ALNUM: begin
            cmd_o.push_char = 1'b1;
            state_d = done_state;
            end_mode_d = sts_i.last;
          end
          iee_pkg::CLS_LPAREN: begin
            cmd_o.push_op = 1'b1;
            state_d = done_state;
            end_mode_d = sts_i.last;
          end
          iee_pkg::CLS_RPAREN, iee_pkg::CLS_OPER: begin
            state_d = iee_pkg::S_UW_RD;
          end
          default: begin
            state_d = done_state;
            end_mode_d = sts_i.last;
          end
        endcase
      end
      iee_pkg::S_UW_RD: begin
        if (sts_i.op_empty) begin
          if (sts_i.cls == iee_pkg::CLS_RPAREN) begin
            cmd_o.err_set  = 1'b1;
            cmd_o.err_code = iee_pkg::ERR_PAREN;
          end else begin
            cmd_o.push_op = 1'b1;
          end
          state_d = done_state;
          end_mode_d = sts_i.last;
        end else begin
          state_d = iee_pkg::S_UW_CHK;
        end
      end
      iee_pkg::S_UW_CHK: begin
        if (sts_i.top_lparen) begin
          if (sts_i.cls == iee_pkg::CLS_RPAREN) begin
            cmd_o.op_pop = 1'b1;
          end else begin
            cmd_o.push_op = 1'b1;
          end
          state_d = done_state;
          end_mode_d = sts_i.last;
        end else if (sts_i.top_prec_lt) begin
          cmd_o.push_op = 1'b1;
          state_d = done_state;
          end_mode_d = sts_i.last;
        end else begin
          cmd_o.op_pop    = 1'b1;
          cmd_o.latch_opr = 1'b1;
          state_d = iee_pkg::S_AP_START;
        end
      end
      iee_pkg::S_AP_START: begin
        if (sts_i.val_lt2) begin
          cmd_o.push_zero = 1'b1;
          cmd_o.err_set   = 1'b1;
          cmd_o.err_code  = iee_pkg::ERR_STACK;
          state_d = ret_state;
        end else begin
          state_d = iee_pkg::S_AP_RB;
        end
      end
      iee_pkg::S_AP_RB: begin
        cmd_o.cap_b      = 1'b1;
        cmd_o.sel_second = 1'b1;
        state_d = iee_pkg::S_AP_RA;
      end
      iee_pkg::S_AP_RA: begin
        cmd_o.cap_a = 1'b1;
        state_d = iee_pkg::S_AP_EXEC;
      end
      iee_pkg::S_AP_EXEC: begin
        if (sts_i.div_needed) begin
          cmd_o.div_start = 1'b1;
          state_d = iee_pkg::S_AP_DIV;
        end else begin
          cmd_o.write_result = 1'b1;
          state_d = ret_state;
        end
      end
      iee_pkg::S_AP_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.write_result = 1'b1;
          state_d = ret_state;
        end
      end
      iee_pkg::S_END_RD: begin
        state_d = sts_i.op_empty ? iee_pkg::S_END_FIN : iee_pkg::S_END_CHK;
      end
      iee_pkg::S_END_CHK: begin
        cmd_o.op_pop = 1'b1;
        if (sts_i.top_lparen) begin
          cmd_o.err_set  = 1'b1;
          cmd_o.err_code = iee_pkg::ERR_PAREN;
          state_d = iee_pkg::S_END_RD;
        end else begin
          cmd_o.latch_opr = 1'b1;
          state_d = iee_pkg::S_AP_START;
        end
      end
      iee_pkg::S_END_FIN: begin
        if (!sts_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          end_mode_d = 1'b0;
          state_d = iee_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = iee_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/iee_dp.sv @@
// ----------------------------------------------------------------------------
// iee_dp: evaluator datapath
// Operator and value stacks, stack counters, arithmetic unit, error flag and
// the result register.
// ----------------------------------------------------------------------------
module iee_dp #(
  parameter int unsigned OPERATOR_DEPTH = 16,
  parameter int unsigned VALUE_DEPTH    = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  iee_in_if.sink         in_i,
  iee_out_if.source      out_o,
  input  iee_pkg::cmd_t  cmd_i,
  output iee_pkg::sts_t  sts_o
);

  localparam int unsigned OpAw = $clog2(OPERATOR_DEPTH);
  localparam int unsigned OpCw = $clog2(OPERATOR_DEPTH + 1);
  localparam int unsigned VAw  = $clog2(VALUE_DEPTH);
  localparam int unsigned VCw  = $clog2(VALUE_DEPTH + 1);

  logic [7:0]      char_q;
  logic            last_q;
  iee_pkg::op_e    opr_q;
  logic [31:0]     a_q, b_q;

  logic [OpCw-1:0] op_cnt_q, op_cnt_d;
  logic [VCw-1:0]  val_cnt_q, val_cnt_d;
  iee_pkg::err_e   err_q, err_d;

  logic            out_valid_q;
  logic [31:0]     out_value_q;
  iee_pkg::err_e   out_err_q;

  logic            op_we;
  logic [OpAw-1:0] op_waddr, op_raddr;
  logic [2:0]      op_wdata, op_rdata;
  logic            val_we;
  logic [VAw-1:0]  val_waddr, val_raddr;
  logic [31:0]     val_wdata, val_rdata;

  iee_pkg::cls_e   cls;
  iee_pkg::op_e    item_op;
  iee_pkg::op_e    top_op;
  logic [31:0]     result;
  logic [31:0]     mag_a, mag_b, quo;
  logic            div_done;
  logic            b_zero;
  iee_pkg::err_e   fin_err;

  assign cls     = iee_pkg::char_class(char_q);
  assign item_op = (cls == iee_pkg::CLS_LPAREN) ? iee_pkg::OP_LPAREN :
                   (cls == iee_pkg::CLS_OPER) ? iee_pkg::op_of(char_q) :
                   iee_pkg::OP_OTHER;
  assign top_op  = iee_pkg::op_e'(op_rdata);
  assign b_zero  = (b_q == '0);

  iee_ram #(.WIDTH(3), .DEPTH(OPERATOR_DEPTH)) u_op_ram (
    .clk_i   (clk_i),
    .we_i    (op_we),
    .waddr_i (op_waddr),
    .wdata_i (op_wdata),
    .raddr_i (op_raddr),
    .rdata_o (op_rdata)
  );

  iee_ram #(.WIDTH(32), .DEPTH(VALUE_DEPTH)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (val_waddr),
    .wdata_i (val_wdata),
    .raddr_i (val_raddr),
    .rdata_o (val_rdata)
  );

  assign mag_a = a_q[31] ? (32'd0 - a_q) : a_q;
  assign mag_b = b_q[31] ? (32'd0 - b_q) : b_q;

  iee_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (mag_a),
    .divisor_i  (mag_b),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  always_comb begin
    case (opr_q)
      iee_pkg::OP_ADD: result = a_q + b_q;
      iee_pkg::OP_SUB: result = a_q - b_q;
      iee_pkg::OP_MUL: result = a_q * b_q;
      iee_pkg::OP_DIV: begin
        if (b_zero) result = '0;
        else if (a_q[31] ^ b_q[31]) result = 32'd0 - quo;
        else result = quo;
      end
      default: result = '0;
    endcase
  end

  assign op_raddr  = OpAw'(op_cnt_q - OpCw'(1));
  assign val_raddr = cmd_i.sel_second ? VAw'(val_cnt_q - VCw'(2)) :
                                        VAw'(val_cnt_q - VCw'(1));

  always_comb begin
    op_cnt_d  = op_cnt_q;
    val_cnt_d = val_cnt_q;
    err_d     = err_q;
    op_we     = 1'b0;
    op_waddr  = OpAw'(op_cnt_q);
    op_wdata  = 3'(item_op);
    val_we    = 1'b0;
    val_waddr = VAw'(val_cnt_q);
    val_wdata = 32'(char_q) - 32'(iee_pkg::CH_ZERO);

    if (cmd_i.err_set && err_q == iee_pkg::ERR_NONE) begin
      err_d = cmd_i.err_code;
    end
    if (cmd_i.push_char) begin
      if (val_cnt_q >= VCw'(VALUE_DEPTH)) begin
        if (err_q == iee_pkg::ERR_NONE) err_d = iee_pkg::ERR_STACK;
      end else begin
        val_we    = 1'b1;
        val_cnt_d = val_cnt_q + VCw'(1);
      end
    end
    if (cmd_i.push_op) begin
      if (op_cnt_q >= OpCw'(OPERATOR_DEPTH)) begin
        if (err_q == iee_pkg::ERR_NONE) err_d = iee_pkg::ERR_STACK;
      end else begin
        op_we    = 1'b1;
        op_cnt_d = op_cnt_q + OpCw'(1);
      end
    end
    if (cmd_i.op_pop) begin
      op_cnt_d = op_cnt_q - OpCw'(1);
    end
    if (cmd_i.push_zero) begin
      val_we    = 1'b1;
      val_waddr = '0;
      val_wdata = '0;
      val_cnt_d = VCw'(1);
    end
    if (cmd_i.write_result) begin
      val_we    = 1'b1;
      val_waddr = VAw'(val_cnt_q - VCw'(2));
      val_wdata = result;
      val_cnt_d = val_cnt_q - VCw'(1);
      if (opr_q == iee_pkg::OP_DIV && b_zero && err_q == iee_pkg::ERR_NONE) begin
        err_d = iee_pkg::ERR_DIV0;
      end
    end
    if (cmd_i.load_out) begin
      op_cnt_d  = '0;
      val_cnt_d = '0;
      err_d     = iee_pkg::ERR_NONE;
    end
  end

  assign fin_err = (err_q != iee_pkg::ERR_NONE) ? err_q :
                   (val_cnt_q != VCw'(1)) ? iee_pkg::ERR_STACK : iee_pkg::ERR_NONE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_cnt_q    <= '0;
      val_cnt_q   <= '0;
      err_q       <= iee_pkg::ERR_NONE;
      out_valid_q <= 1'b0;
    end else begin
      op_cnt_q  <= op_cnt_d;
      val_cnt_q <= val_cnt_d;
      err_q     <= err_d;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && cmd_i.in_ready) begin
      char_q <= in_i.char_code;
      last_q <= in_i.last_char;
    end
    if (cmd_i.latch_opr) opr_q <= top_op;
    if (cmd_i.cap_b) b_q <= val_rdata;
    if (cmd_i.cap_a) a_q <= val_rdata;
    if (cmd_i.load_out) begin
      out_value_q <= (val_cnt_q != '0) ? val_rdata : '0;
      out_err_q   <= fin_err;
    end
  end

  assign in_i.ready       = cmd_i.in_ready;
  assign out_o.valid      = out_valid_q;
  assign out_o.value      = out_value_q;
  assign out_o.error_code = out_err_q;

  assign sts_o.cls         = cls;
  assign sts_o.last        = last_q;
  assign sts_o.op_empty    = (op_cnt_q == '0);
  assign sts_o.top_lparen  = (top_op == iee_pkg::OP_LPAREN);
  assign sts_o.top_prec_lt = iee_pkg::prec_of(top_op) < iee_pkg::prec_of(item_op);
  assign sts_o.val_lt2     = (val_cnt_q < VCw'(2));
  assign sts_o.div_needed  = (opr_q == iee_pkg::OP_DIV) && !b_zero;
  assign sts_o.div_done    = div_done;
  assign sts_o.out_busy    = out_valid_q && !out_o.ready;

endmodule

@@ hdl/infix_expression_evaluator.sv @@
// ----------------------------------------------------------------------------
// infix_expression_evaluator: infix expression evaluator
// Each space, operand or '(' is dispatched directly; each operator applied
// reads its two operands from the value stack, and a divide also waits for
// the iterative divider; stacked operators are inspected one by one in the
// unwinding loop. Characters are taken one at a time: the next is accepted
// only once the last is done. Reset clears both stack counts, the error flag
// and the output valid flag; stack contents need no clearing.
module infix_expression_evaluator #(
  parameter int unsigned OPERATOR_DEPTH = 16,
  parameter int unsigned VALUE_DEPTH    = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  iee_in_if.sink     in_i,
  iee_out_if.source  out_o
);

  iee_pkg::cmd_t cmd;
  iee_pkg::sts_t sts;

  iee_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sts_i      (sts),
    .in_valid_i (in_i.valid),
    .cmd_o      (cmd)
  );

  iee_dp #(
    .OPERATOR_DEPTH (OPERATOR_DEPTH),
    .VALUE_DEPTH    (VALUE_DEPTH)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .out_o  (out_o),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

endmodule
